/* sv/smix_pkg.sv */
// Shared types and constants of the stereo mix bus with gain, clip and level meter.
package smix_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int GAIN_W       = 16;
   localparam int GAIN_FRAC    = 14;
   localparam int BUS_W        = 21;
   localparam int LEVEL_W      = 16;
   localparam int BUF_LEN_W    = 13;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd16384;
   localparam logic [BUF_LEN_W-1:0] BUF_LEN_RESET = 13'd512;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_LEFT          = 3'd0,
      CSR_GAIN_RIGHT         = 3'd1,
      CSR_MUTE_LEFT          = 3'd2,
      CSR_MUTE_RIGHT         = 3'd3,
      CSR_SAMPLES_PER_BUFFER = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
      logic                       mono;
      logic                       last_channel;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mix_left;
      logic signed [SAMPLE_W-1:0] mix_right;
      logic                       level_valid;
      logic [LEVEL_W-1:0]         level_left;
      logic [LEVEL_W-1:0]         level_right;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] level;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN_LEFT,
      ST_GAIN_RIGHT,
      ST_LEVEL,
      ST_DIV_LEFT_GO,
      ST_DIV_LEFT_WAIT,
      ST_DIV_RIGHT_GO,
      ST_DIV_RIGHT_WAIT,
      ST_OUT
   } state_type;

endpackage

/* sv/stereo_mix_bus_gain_clip_meter_unit.sv */
// Stereo mix bus top level: bus accumulation, master gain and clip, level meter, handshakes.
//
// Each request carries one channel's sample pair and is added into the stereo bus in the
// cycle it is accepted, so a request that does not end a frame leaves the block ready for
// further requests. After a request that ends a frame, no request is accepted until the
// frame is finished: the shared gain multiplier scales the left and then the right bus
// sample, the level sums are updated, and the result is loaded into the output register,
// waiting until the previous result, if any, has been taken. On the frame that ends a
// metering buffer the one restoring divider computes the left and then the right mean
// level, one quotient bit per cycle.
// Configuration writes are always accepted and must be issued only while the block is idle.
module stereo_mix_bus_gain_clip_meter_unit
   import smix_pkg::*;
#(
   parameter int MAX_BUFFER_FRAMES = 4096
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COUNT_W = $clog2(MAX_BUFFER_FRAMES + 1);
   localparam int SUM_W   = COUNT_W + SAMPLE_W - 1;

   state_type state_ff, state_in;

   logic [GAIN_W-1:0]    gain_left_ff, gain_left_in;
   logic [GAIN_W-1:0]    gain_right_ff, gain_right_in;
   logic                 mute_left_ff, mute_left_in;
   logic                 mute_right_ff, mute_right_in;
   logic [BUF_LEN_W-1:0] spb_ff, spb_in;

   logic signed [BUS_W-1:0]    bus_left_ff, bus_left_in;
   logic signed [BUS_W-1:0]    bus_right_ff, bus_right_in;
   logic [SUM_W-1:0]           level_sum_left_ff, level_sum_left_in;
   logic [SUM_W-1:0]           level_sum_right_ff, level_sum_right_in;
   logic [COUNT_W-1:0]         frame_count_ff, frame_count_in;
   logic signed [SAMPLE_W-1:0] mix_left_ff, mix_left_in;
   logic signed [SAMPLE_W-1:0] mix_right_ff, mix_right_in;
   logic                       level_valid_ff, level_valid_in;
   logic [LEVEL_W-1:0]         level_left_ff, level_left_in;
   logic [LEVEL_W-1:0]         level_right_ff, level_right_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       gain_pick_right;
   logic                       div_start;
   logic                       div_pick_right;
   logic                       out_load;
   logic                       accept;
   logic                       buffer_end;
   logic [COUNT_W-1:0]         buf_len;
   logic [COUNT_W-1:0]         count_plus;
   logic signed [SAMPLE_W-1:0] right_in_sample;
   logic signed [BUS_W-1:0]    gain_bus;
   logic [GAIN_W-1:0]          gain_applied;
   logic signed [SAMPLE_W-1:0] gain_result;
   logic [SAMPLE_W-1:0]        mag_left;
   logic [SAMPLE_W-1:0]        mag_right;
   logic [SUM_W-1:0]           div_dividend;
   div_status_type             div_status;

   function automatic logic signed [BUS_W-1:0] bus_add(
      input logic signed [BUS_W-1:0]    acc,
      input logic signed [SAMPLE_W-1:0] sample
   );
      logic signed [BUS_W:0] sum;
      sum = (BUS_W + 1)'(acc) + (BUS_W + 1)'(sample);
      if (sum > (BUS_W + 1)'(signed'((1 << (BUS_W - 1)) - 1))) begin
         return BUS_W'(signed'((1 << (BUS_W - 1)) - 1));
      end else if (sum < (BUS_W + 1)'(signed'(-(1 << (BUS_W - 1))))) begin
         return BUS_W'(signed'(-(1 << (BUS_W - 1))));
      end
      return sum[BUS_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] value);
      return value[SAMPLE_W-1] ? (~value + SAMPLE_W'(1)) : value;
   endfunction

   // Effective buffer length: zero acts as one, and it is capped at the maximum.
   always_comb begin
      if (spb_ff == '0) begin
         buf_len = COUNT_W'(1);
      end else if (32'(spb_ff) > 32'(MAX_BUFFER_FRAMES)) begin
         buf_len = COUNT_W'(MAX_BUFFER_FRAMES);
      end else begin
         buf_len = COUNT_W'(spb_ff);
      end
   end

   assign accept          = req_valid && req_ready;
   assign count_plus      = frame_count_ff + COUNT_W'(1);
   assign buffer_end      = count_plus >= buf_len;
   assign right_in_sample = req_data.mono ? req_data.sample_left : req_data.sample_right;
   assign mag_left        = magnitude(mix_left_ff);
   assign mag_right       = magnitude(gain_result);

   assign gain_bus = gain_pick_right ? bus_right_ff : bus_left_ff;
   always_comb begin
      if (gain_pick_right) begin
         gain_applied = mute_right_ff ? '0 : gain_right_ff;
      end else begin
         gain_applied = mute_left_ff ? '0 : gain_left_ff;
      end
   end

   assign div_dividend = div_pick_right ? level_sum_right_ff : level_sum_left_ff;

   smix_gain u_gain (
      .clock  (clock),
      .bus    (gain_bus),
      .gain   (gain_applied),
      .result (gain_result)
   );

   smix_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (COUNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (buf_len),
      .status   (div_status)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.last_channel) begin
               state_in = ST_GAIN_LEFT;
            end
         end
         ST_GAIN_LEFT:  state_in = ST_GAIN_RIGHT;
         ST_GAIN_RIGHT: state_in = ST_LEVEL;
         ST_LEVEL:      state_in = buffer_end ? ST_DIV_LEFT_GO : ST_OUT;
         ST_DIV_LEFT_GO: state_in = ST_DIV_LEFT_WAIT;
         ST_DIV_LEFT_WAIT: begin
            if (div_status.done) begin
               state_in = ST_DIV_RIGHT_GO;
            end
         end
         ST_DIV_RIGHT_GO: state_in = ST_DIV_RIGHT_WAIT;
         ST_DIV_RIGHT_WAIT: begin
            if (div_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      gain_pick_right = 1'b0;
      div_start       = 1'b0;
      div_pick_right  = 1'b0;
      out_load        = 1'b0;
      case (state_ff)
         ST_IDLE:           req_ready = 1'b1;
         ST_GAIN_LEFT:      gain_pick_right = 1'b0;
         ST_GAIN_RIGHT:     gain_pick_right = 1'b1;
         ST_LEVEL:          gain_pick_right = 1'b1;
         ST_DIV_LEFT_GO:    div_start = 1'b1;
         ST_DIV_LEFT_WAIT:  div_pick_right = 1'b0;
         ST_DIV_RIGHT_GO: begin
            div_start      = 1'b1;
            div_pick_right = 1'b1;
         end
         ST_DIV_RIGHT_WAIT: div_pick_right = 1'b1;
         ST_OUT:            out_load = !rsp_valid_ff || rsp_ready;
         default:           req_ready = 1'b0;
      endcase
   end

   always_comb begin
      gain_left_in       = gain_left_ff;
      gain_right_in      = gain_right_ff;
      mute_left_in       = mute_left_ff;
      mute_right_in      = mute_right_ff;
      spb_in             = spb_ff;
      bus_left_in        = bus_left_ff;
      bus_right_in       = bus_right_ff;
      level_sum_left_in  = level_sum_left_ff;
      level_sum_right_in = level_sum_right_ff;
      frame_count_in     = frame_count_ff;
      mix_left_in        = mix_left_ff;
      mix_right_in       = mix_right_ff;
      level_valid_in     = level_valid_ff;
      level_left_in      = level_left_ff;
      level_right_in     = level_right_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_LEFT:          gain_left_in = csr_data[GAIN_W-1:0];
            CSR_GAIN_RIGHT:         gain_right_in = csr_data[GAIN_W-1:0];
            CSR_MUTE_LEFT:          mute_left_in = csr_data[0];
            CSR_MUTE_RIGHT:         mute_right_in = csr_data[0];
            CSR_SAMPLES_PER_BUFFER: spb_in = csr_data[BUF_LEN_W-1:0];
            default:                spb_in = spb_ff;
         endcase
      end

      if (accept) begin
         bus_left_in  = bus_add(bus_left_ff, req_data.sample_left);
         bus_right_in = bus_add(bus_right_ff, right_in_sample);
      end

      case (state_ff)
         ST_GAIN_RIGHT: mix_left_in = gain_result;
         ST_LEVEL: begin
            mix_right_in       = gain_result;
            bus_left_in        = '0;
            bus_right_in       = '0;
            level_sum_left_in  = level_sum_left_ff + SUM_W'(mag_left);
            level_sum_right_in = level_sum_right_ff + SUM_W'(mag_right);
            level_valid_in     = buffer_end;
            frame_count_in     = buffer_end ? '0 : count_plus;
         end
         ST_DIV_LEFT_WAIT: begin
            if (div_status.done) begin
               level_left_in = div_status.level;
            end
         end
         ST_DIV_RIGHT_WAIT: begin
            if (div_status.done) begin
               level_right_in     = div_status.level;
               level_sum_left_in  = '0;
               level_sum_right_in = '0;
            end
         end
         default: mix_left_in = mix_left_ff;
      endcase

      if (out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.mix_left    = mix_left_ff;
         rsp_data_in.mix_right   = mix_right_ff;
         rsp_data_in.level_valid = level_valid_ff;
         rsp_data_in.level_left  = level_valid_ff ? level_left_ff : '0;
         rsp_data_in.level_right = level_valid_ff ? level_right_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         gain_left_ff       <= GAIN_RESET;
         gain_right_ff      <= GAIN_RESET;
         mute_left_ff       <= 1'b0;
         mute_right_ff      <= 1'b0;
         spb_ff             <= BUF_LEN_RESET;
         bus_left_ff        <= '0;
         bus_right_ff       <= '0;
         level_sum_left_ff  <= '0;
         level_sum_right_ff <= '0;
         frame_count_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         gain_left_ff       <= gain_left_in;
         gain_right_ff      <= gain_right_in;
         mute_left_ff       <= mute_left_in;
         mute_right_ff      <= mute_right_in;
         spb_ff             <= spb_in;
         bus_left_ff        <= bus_left_in;
         bus_right_ff       <= bus_right_in;
         level_sum_left_ff  <= level_sum_left_in;
         level_sum_right_ff <= level_sum_right_in;
         frame_count_ff     <= frame_count_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      mix_left_ff    <= mix_left_in;
      mix_right_ff   <= mix_right_in;
      level_valid_ff <= level_valid_in;
      level_left_ff  <= level_left_in;
      level_right_ff <= level_right_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/smix_gain.sv */
// Master gain multiplier with rounding to Q1.15 and clipping, registered output.
module smix_gain
   import smix_pkg::*;
(
   input  logic                       clock,
   input  logic signed [BUS_W-1:0]    bus,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int PROD_W = BUS_W + GAIN_W + 1;

   logic signed [PROD_W-1:0]   product;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [PROD_W-1:0]   scaled;
   logic signed [SAMPLE_W-1:0] result_in;
   logic signed [SAMPLE_W-1:0] result_ff;

   assign product = PROD_W'(bus) * PROD_W'($signed({1'b0, gain}));
   assign rounded = product + PROD_W'(signed'(1 << (GAIN_FRAC - 1)));
   assign scaled  = rounded >>> GAIN_FRAC;

   always_comb begin
      if (scaled > PROD_W'(signed'((1 << (SAMPLE_W - 1)) - 1))) begin
         result_in = SAMPLE_W'(signed'((1 << (SAMPLE_W - 1)) - 1));
      end else if (scaled < PROD_W'(signed'(-(1 << (SAMPLE_W - 1))))) begin
         result_in = SAMPLE_W'(signed'(-(1 << (SAMPLE_W - 1))));
      end else begin
         result_in = scaled[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* sv/smix_div.sv */
// Restoring divider that produces one quotient bit per cycle for the level meter.
module smix_div
   import smix_pkg::*;
#(
   parameter int DIVIDEND_W = 28,
   parameter int DIVISOR_W  = 13
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_status_type        status
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;

   assign shifted = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial[DIVISOR_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DIVISOR_W:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.done  = done_ff;
   assign status.level = quo_ff[LEVEL_W-1:0];

endmodule

/* sv/smix_checker.sv */
// Port-level checker for the stereo mix bus top level, with its bind statement.
module smix_checker
   import smix_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response dropped or changed while stalled.");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_channel |=> !req_ready)
      else $error("Request accepted while a frame was being finished.");

   a_ready_after_mid: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.last_channel |=> req_ready)
      else $error("Ready dropped after a request that does not end a frame.");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.level_valid |->
         rsp_data.level_left == '0 && rsp_data.level_right == '0)
      else $error("Level fields nonzero on a response without levels.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("Configuration write not accepted.");

endmodule

bind stereo_mix_bus_gain_clip_meter_unit smix_checker u_smix_checker (.*);
